// ===== design/fad_pkg.sv =====
// ----------------------------------------------------------------------------
// fad_pkg
// shared types and constants of the fault address decoder
// ----------------------------------------------------------------------------
package fad_pkg;

    localparam int unsigned GUARD_BYTES = 32;
    localparam int unsigned RF_DEPTH    = 32;
    localparam int unsigned RF_AW       = $clog2(RF_DEPTH);
    localparam int unsigned CFG_IDX_W   = 3;

    // request operations
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // mcause
    localparam logic [30:0] CAUSE_LOAD_FAULT  = 31'd5;
    localparam logic [30:0] CAUSE_STORE_FAULT = 31'd7;

    // full-width opcodes
    localparam logic [6:0] OPC_LOAD  = 7'h03;
    localparam logic [6:0] OPC_STORE = 7'h23;
    localparam logic [6:0] OPC_AMO   = 7'h2f;
    localparam logic [2:0] F3_AMO_W  = 3'd2;

    // compressed encodings
    localparam logic [1:0] QUAD_0    = 2'b00;
    localparam logic [1:0] QUAD_2    = 2'b10;
    localparam logic [1:0] QUAD_FULL = 2'b11;
    localparam logic [2:0] C_F3_LW   = 3'd2;
    localparam logic [2:0] C_F3_SW   = 3'd6;
    localparam logic [RF_AW-1:0] SP_INDEX = RF_AW'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLASH_BASE = 3'd0,
        CFG_FLASH_END  = 3'd1,
        CFG_SRAM_BASE  = 3'd2,
        CFG_SRAM_END   = 3'd3,
        CFG_GUARD_BASE = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic        operation;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic [31:0] instr_word;
        logic [31:0] trap_cause;
        logic [31:0] fault_pc;
    } req_item_t;

    typedef struct packed {
        logic        address_found;
        logic [31:0] data_addr;
        logic        hits_guard;
    } res_item_t;

    typedef struct packed {
        logic [31:0] flash_base;
        logic [31:0] flash_end;
        logic [31:0] ram_base;
        logic [31:0] ram_end;
        logic [31:0] guard_base;
        logic [31:0] guard_end;
    } cfg_t;

    typedef struct packed {
        logic             found;
        logic [RF_AW-1:0] rs_index;
        logic [31:0]      offset;
    } dec_t;

endpackage

// ===== design/riscv_fault_address_decoder.sv =====
// ----------------------------------------------------------------------------
// riscv_fault_address_decoder
// recomputes the effective address of a faulting rv32ic load or store
// ----------------------------------------------------------------------------
// usage
//   request channel (req_valid / req_stall / req_data): a write request loads
//   one register file entry and gives no result; a decode request gives
//   exactly one result on the result channel (res_valid / res_stall /
//   res_data).
//   configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data)
//   is always ready; write it only while no request is in flight.
// pipeline and throughput
//   the register file is read at the edge that accepts a decode request;
//   the base plus offset add and guard compare then load the output
//   register, which drives res_valid. one request per cycle is sustained
//   while a stalled result does not hold the output register.
// reset
//   all windows and the guard base clear to zero; per-entry valid flops make
//   every register file entry read as zero until written, no clearing pass.
// stall
//   a stalled result holds in the output register; one more decode may sit
//   in the read stage, after which req_stall rises until the result moves.
// ----------------------------------------------------------------------------
module riscv_fault_address_decoder
    import fad_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_item_t            req_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_item_t            res_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    cfg_t  cfg;
    dec_t  dec;

    logic              req_acc;
    logic              rf_wr;
    logic              rf_rd;
    logic [31:0]       rf_rd_data;
    logic [RF_DEPTH-1:0] rf_valid_reg;
    logic [RF_DEPTH-1:0] rf_valid_next;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_found_reg;
    logic              s1_base_ok_reg;
    logic [31:0]       s1_offset_reg;

    logic              out_load;
    logic              res_valid_reg;
    logic              res_valid_next;
    res_item_t         res_reg;
    res_item_t         res_next;
    logic [31:0]       base;
    logic [31:0]       addr;

    fad_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fad_decode u_dec (
        .req (req_data),
        .cfg (cfg),
        .dec (dec)
    );

    // one request per edge, so a read never meets a write in the same cycle
    fad_ram #(
        .WIDTH (32),
        .DEPTH (RF_DEPTH)
    ) u_rf (
        .clk     (clk),
        .wr_en   (rf_wr),
        .wr_addr (req_data.reg_index),
        .wr_data (req_data.reg_value),
        .rd_en   (rf_rd),
        .rd_addr (dec.rs_index),
        .rd_data (rf_rd_data)
    );

    assign out_load  = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign req_stall = s1_valid_reg && !out_load;
    assign req_acc   = req_valid && !req_stall;
    assign rf_wr     = req_acc && req_data.operation == OP_WRITE;
    assign rf_rd     = req_acc && req_data.operation == OP_DECODE;

    always_comb
    begin
        rf_valid_next = rf_valid_reg;
        if (rf_wr)
        begin
            rf_valid_next[req_data.reg_index] = 1'b1;
        end

        s1_valid_next = rf_rd || (s1_valid_reg && !out_load);

        // entries never written read as zero
        base = s1_base_ok_reg ? rf_rd_data : '0;
        addr = s1_found_reg ? base + s1_offset_reg : '0;

        res_next.address_found = s1_found_reg;
        res_next.data_addr     = addr;
        res_next.hits_guard    = s1_found_reg && cfg.guard_base != '0
                              && addr >= cfg.guard_base && addr < cfg.guard_end;

        res_valid_next = out_load || (res_valid_reg && res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            rf_valid_reg  <= rf_valid_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_rd)
        begin
            s1_found_reg   <= dec.found;
            s1_base_ok_reg <= rf_valid_reg[dec.rs_index];
            s1_offset_reg  <= dec.offset;
        end
        if (out_load)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // a result that is not found carries zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.address_found |->
            res_reg.data_addr == '0 && !res_reg.hits_guard)
        else $error("not-found result carries nonzero payload");

    // backpressure only while both stages are occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s1_valid_reg && res_valid_reg && res_stall)
        else $error("request stalled with a free stage");

    // a written entry is valid from the next cycle on
    assert property (@(posedge clk) disable iff (!rst_n)
        rf_wr |=> rf_valid_reg[$past(req_data.reg_index)])
        else $error("register file entry not marked valid after write");

    // a decode accepted reaches the read stage
    assert property (@(posedge clk) disable iff (!rst_n)
        rf_rd |=> s1_valid_reg)
        else $error("decode request lost before the read stage");

endmodule

// ===== design/fad_ram.sv =====
// ----------------------------------------------------------------------------
// fad_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module fad_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/fad_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fad_cfg_regs
// window and guard configuration registers
// ----------------------------------------------------------------------------
module fad_cfg_regs
    import fad_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_FLASH_BASE: cfg_next.flash_base = cfg_data;
                CFG_FLASH_END:  cfg_next.flash_end  = cfg_data;
                CFG_SRAM_BASE:  cfg_next.ram_base   = cfg_data;
                CFG_SRAM_END:   cfg_next.ram_end    = cfg_data;
                CFG_GUARD_BASE:
                begin
                    cfg_next.guard_base = cfg_data;
                    // window end wraps modulo 2^32
                    cfg_next.guard_end  = cfg_data + 32'(GUARD_BYTES);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{flash_base: '0, flash_end: '0, ram_base: '0, ram_end: '0,
                         guard_base: '0, guard_end: 32'(GUARD_BYTES)};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

// ===== design/fad_decode.sv =====
// ----------------------------------------------------------------------------
// fad_decode
// pc window and cause checks, instruction decode into base register and offset
// ----------------------------------------------------------------------------
module fad_decode
    import fad_pkg::*;
(
    input  req_item_t req,
    input  cfg_t      cfg,
    output dec_t      dec
);

    function automatic logic span_ok(input logic [31:0] pc, input logic [1:0] extra,
                                     input logic [31:0] base, input logic [31:0] lim);
        logic [32:0] last;
        last = {1'b0, pc} + {31'd0, extra};
        return !last[32] && (pc >= base) && (last[31:0] < lim);
    endfunction

    logic [15:0] half;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [2:0]  cf3;
    logic [1:0]  quad;
    logic        is_ld;
    logic        is_st;
    logic        win2;
    logic        win4;
    logic        cause_ok;
    logic        m_load;
    logic        m_store;
    logic        m_amo;
    logic        m_clsw;
    logic        m_lwsp;
    logic        m_swsp;

    always_comb
    begin
        half  = req.instr_word[15:0];
        opc   = req.instr_word[6:0];
        f3    = req.instr_word[14:12];
        cf3   = half[15:13];
        quad  = half[1:0];
        is_ld = req.trap_cause[30:0] == CAUSE_LOAD_FAULT;
        is_st = req.trap_cause[30:0] == CAUSE_STORE_FAULT;

        win2 = span_ok(req.fault_pc, 2'd1, cfg.flash_base, cfg.flash_end)
            || span_ok(req.fault_pc, 2'd1, cfg.ram_base, cfg.ram_end);
        win4 = span_ok(req.fault_pc, 2'd3, cfg.flash_base, cfg.flash_end)
            || span_ok(req.fault_pc, 2'd3, cfg.ram_base, cfg.ram_end);
        cause_ok = !req.trap_cause[31] && (is_ld || is_st);

        m_load  = is_ld && opc == OPC_LOAD && f3 != 3'd3 && f3 != 3'd6 && f3 != 3'd7;
        m_store = is_st && opc == OPC_STORE && f3 <= 3'd2;
        m_amo   = is_st && opc == OPC_AMO && f3 == F3_AMO_W;
        m_clsw  = quad == QUAD_0 && ((is_ld && cf3 == C_F3_LW) || (is_st && cf3 == C_F3_SW));
        m_lwsp  = quad == QUAD_2 && is_ld && cf3 == C_F3_LW && half[11:7] != 5'd0;
        m_swsp  = quad == QUAD_2 && is_st && cf3 == C_F3_SW;

        dec.rs_index = req.instr_word[19:15];
        dec.offset   = '0;
        if (quad == QUAD_FULL)
        begin
            dec.found = win4 && (m_load || m_store || m_amo);
            if (m_load)
            begin
                dec.offset = {{20{req.instr_word[31]}}, req.instr_word[31:20]};
            end
            else if (m_store)
            begin
                dec.offset = {{20{req.instr_word[31]}}, req.instr_word[31:25],
                              req.instr_word[11:7]};
            end
        end
        else
        begin
            dec.found = m_clsw || m_lwsp || m_swsp;
            if (m_clsw)
            begin
                dec.rs_index = {2'b01, half[9:7]};
                dec.offset   = {25'd0, half[5], half[12:10], half[6], 2'b00};
            end
            else if (m_lwsp)
            begin
                dec.rs_index = SP_INDEX;
                dec.offset   = {24'd0, half[3:2], half[12], half[6:4], 2'b00};
            end
            else
            begin
                dec.rs_index = SP_INDEX;
                dec.offset   = {24'd0, half[8:7], half[12:9], 2'b00};
            end
        end
        dec.found = dec.found && win2 && cause_ok;
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// randomized check of the fault address decoder: register file writes and
// fault decode requests under random idling on both sides, with results
// compared in order against an in-bench predictor across several window and
// guard settings
// ----------------------------------------------------------------------------
module testbench
    import fad_pkg::*;
();

    localparam logic [31:0] LD_CAUSE = {1'b0, CAUSE_LOAD_FAULT};
    localparam logic [31:0] ST_CAUSE = {1'b0, CAUSE_STORE_FAULT};

    // expected results of the decoder, kept in request order
    class fault_addr_scoreboard;
        logic [31:0] flash_base, flash_end, ram_base, ram_end, guard_base;
        logic [RF_DEPTH-1:0][31:0] regs;
        res_item_t pending_results[$];
        int mismatches, writes, decodes, found_cnt, guard_hits;

        function new();
            flash_base = '0;
            flash_end  = '0;
            ram_base   = '0;
            ram_end    = '0;
            guard_base = '0;
            regs       = '0;
            mismatches = 0;
            writes     = 0;
            decodes    = 0;
            found_cnt  = 0;
            guard_hits = 0;
        endfunction

        function void set_window(cfg_index_t idx, logic [31:0] v);
            case (idx)
                CFG_FLASH_BASE: flash_base = v;
                CFG_FLASH_END:  flash_end  = v;
                CFG_SRAM_BASE:  ram_base   = v;
                CFG_SRAM_END:   ram_end    = v;
                CFG_GUARD_BASE: guard_base = v;
                default: ;
            endcase
        endfunction

        function bit span_ok(logic [31:0] pc, logic [31:0] size);
            logic [31:0] last;
            last = pc + size - 32'd1;
            if (last < pc)
                return 1'b0;
            return (pc >= flash_base && last < flash_end) ||
                   (pc >= ram_base && last < ram_end);
        endfunction

        function res_item_t predict_decode(req_item_t r);
            res_item_t   res;
            logic [15:0] h;
            logic [31:0] w, base, off, addr, gend;
            logic [30:0] code;
            logic [2:0]  f3;
            bit          is_ld, is_st, found;
            w     = r.instr_word;
            h     = w[15:0];
            code  = r.trap_cause[30:0];
            is_ld = (code == CAUSE_LOAD_FAULT);
            is_st = (code == CAUSE_STORE_FAULT);
            found = 1'b0;
            base  = '0;
            off   = '0;
            if (span_ok(r.fault_pc, 32'd2) && !r.trap_cause[31] && (is_ld || is_st)) begin
                if (h[1:0] == QUAD_FULL) begin
                    f3 = w[14:12];
                    if (span_ok(r.fault_pc, 32'd4)) begin
                        base = regs[w[19:15]];
                        if (is_ld && w[6:0] == OPC_LOAD && f3 != 3'd3 && f3 < 3'd6) begin
                            found = 1'b1;
                            off   = {{20{w[31]}}, w[31:20]};
                        end else if (is_st && w[6:0] == OPC_STORE && f3 <= 3'd2) begin
                            found = 1'b1;
                            off   = {{20{w[31]}}, w[31:25], w[11:7]};
                        end else if (is_st && w[6:0] == OPC_AMO && f3 == F3_AMO_W) begin
                            found = 1'b1;
                        end
                    end
                end else if (h[1:0] == QUAD_0 &&
                             ((is_ld && h[15:13] == C_F3_LW) || (is_st && h[15:13] == C_F3_SW))) begin
                    found = 1'b1;
                    base  = regs[{2'b01, h[9:7]}];
                    off   = {25'd0, h[5], h[12:10], h[6], 2'b00};
                end else if (h[1:0] == QUAD_2 && is_ld && h[15:13] == C_F3_LW && h[11:7] != 5'd0) begin
                    found = 1'b1;
                    base  = regs[SP_INDEX];
                    off   = {24'd0, h[3:2], h[12], h[6:4], 2'b00};
                end else if (h[1:0] == QUAD_2 && is_st && h[15:13] == C_F3_SW) begin
                    found = 1'b1;
                    base  = regs[SP_INDEX];
                    off   = {24'd0, h[8:7], h[12:9], 2'b00};
                end
            end
            addr = found ? base + off : 32'd0;
            // a guard window that wraps past the top catches nothing
            gend = guard_base + 32'(GUARD_BYTES);
            res.address_found = found;
            res.data_addr     = addr;
            res.hits_guard    = found && guard_base != 0 && addr >= guard_base && addr < gend;
            return res;
        endfunction

        function void note_request(req_item_t r);
            res_item_t res;
            if (r.operation == OP_WRITE) begin
                regs[r.reg_index] = r.reg_value;
                writes++;
            end else begin
                res = predict_decode(r);
                pending_results.push_back(res);
                decodes++;
                if (res.address_found)
                    found_cnt++;
                if (res.hits_guard)
                    guard_hits++;
            end
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_result(res_item_t got);
            res_item_t exp_res;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            exp_res = pending_results.pop_front();
            if (got.address_found !== exp_res.address_found)
                report($sformatf("address_found exp %b got %b",
                                 exp_res.address_found, got.address_found));
            if (got.data_addr !== exp_res.data_addr)
                report($sformatf("data_addr exp %h got %h",
                                 exp_res.data_addr, got.data_addr));
            if (got.hits_guard !== exp_res.hits_guard)
                report($sformatf("hits_guard exp %b got %b",
                                 exp_res.hits_guard, got.hits_guard));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_item_t req_data;
    logic res_valid;
    logic res_stall;
    res_item_t res_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    fault_addr_scoreboard sb;
    bit quiet;
    int hold_requests;
    int settings_used;

    riscv_fault_address_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res_data);
    end

    // result side: random stall per result, one long hold-off on request
    initial
    begin : result_sink
        int unsigned hold;
        int holds_done;
        holds_done = 0;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_requests > holds_done) begin
                hold = 120;
                holds_done++;
            end else begin
                hold = quiet ? 0 : $urandom_range(0, 14);
            end
            if (hold != 0) begin
                res_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            res_stall <= 1'b0;
            do
                @(posedge clk);
            while (!res_valid);
        end
    end

    function automatic logic [31:0] enc_i(logic [6:0] opc, logic [2:0] f3,
                                          logic [4:0] rs1, logic [11:0] imm);
        return {imm, rs1, f3, 5'($urandom), opc};
    endfunction

    function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [11:0] imm);
        return {imm[11:5], 5'($urandom), rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_cl(logic [2:0] f3, logic [2:0] rs1p, logic [6:0] imm);
        return {16'($urandom), f3, imm[5:3], rs1p, imm[2], imm[6], 3'($urandom), QUAD_0};
    endfunction

    function automatic logic [31:0] enc_lwsp(logic [4:0] rd, logic [7:0] imm);
        return {16'($urandom), C_F3_LW, imm[5], rd, imm[4:2], imm[7:6], QUAD_2};
    endfunction

    function automatic logic [31:0] enc_swsp(logic [7:0] imm);
        return {16'($urandom), C_F3_SW, imm[5:2], imm[7:6], 5'($urandom), QUAD_2};
    endfunction

    function automatic logic [11:0] pick_imm12();
        return ($urandom_range(0, 1) != 0) ? 12'($urandom) : 12'($urandom_range(0, 63));
    endfunction

    function automatic logic [31:0] pick_instr(output bit store_kind);
        logic [31:0] w;
        store_kind = 1'b0;
        case ($urandom_range(0, 9))
            0, 1: w = enc_i(OPC_LOAD, 3'($urandom), 5'($urandom), pick_imm12());
            2: begin
                w = enc_s(3'($urandom_range(0, 3)), 5'($urandom), pick_imm12());
                store_kind = 1'b1;
            end
            3: begin
                w = enc_i(OPC_AMO, ($urandom_range(0, 2) != 0) ? F3_AMO_W : 3'($urandom),
                          5'($urandom), 12'($urandom));
                store_kind = 1'b1;
            end
            4: begin
                w = $urandom;
                w[1:0] = QUAD_FULL;
                store_kind = 1'($urandom);
            end
            5: w = enc_cl(C_F3_LW, 3'($urandom), 7'($urandom));
            6: begin
                w = enc_cl(C_F3_SW, 3'($urandom), 7'($urandom));
                store_kind = 1'b1;
            end
            7: w = enc_lwsp(($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom), 8'($urandom));
            8: begin
                w = enc_swsp(8'($urandom));
                store_kind = 1'b1;
            end
            default: begin
                w = $urandom;
                store_kind = 1'($urandom);
            end
        endcase
        return w;
    endfunction

    function automatic logic [31:0] pick_cause(bit store_kind);
        logic [31:0] c;
        c = store_kind ? ST_CAUSE : LD_CAUSE;
        case ($urandom_range(0, 9))
            7: return store_kind ? LD_CAUSE : ST_CAUSE;
            8: return c | 32'h8000_0000;
            9: return $urandom;
            default: return c;
        endcase
    endfunction

    function automatic logic [31:0] pick_pc();
        logic [31:0] lo, hi;
        if ($urandom_range(0, 1) != 0) begin
            lo = sb.ram_base;
            hi = sb.ram_end;
        end else begin
            lo = sb.flash_base;
            hi = sb.flash_end;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return (hi > lo) ? lo + ($urandom % (hi - lo)) : lo;
            6, 7: return hi - $urandom_range(1, 5);
            8: return lo - $urandom_range(0, 2);
            default: return ($urandom_range(0, 1) != 0) ? $urandom
                                                        : 32'hffff_fff8 + $urandom_range(0, 7);
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2, 3: return sb.guard_base - $urandom_range(0, 160);
            4: return 32'hffff_ffff - $urandom_range(0, 2047);
            default: return $urandom_range(0, 2047);
        endcase
    endfunction

    // starts and ends at a falling edge; valid stays high between requests with no gap
    task automatic send_req(input req_item_t r);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(r);
        @(negedge clk);
    endtask

    function automatic req_item_t random_fill();
        req_item_t r;
        r.operation  = 1'($urandom);
        r.reg_index  = 5'($urandom);
        r.reg_value  = $urandom;
        r.instr_word = $urandom;
        r.trap_cause = $urandom;
        r.fault_pc   = $urandom;
        return r;
    endfunction

    task automatic send_write(input logic [4:0] idx, input logic [31:0] v);
        req_item_t r;
        r = random_fill();
        r.operation = OP_WRITE;
        r.reg_index = idx;
        r.reg_value = v;
        send_req(r);
    endtask

    task automatic send_decode(input logic [31:0] insn, input logic [31:0] cause,
                               input logic [31:0] pc);
        req_item_t r;
        r = random_fill();
        r.operation  = OP_DECODE;
        r.instr_word = insn;
        r.trap_cause = cause;
        r.fault_pc   = pc;
        send_req(r);
    endtask

    // drains the block, then writes all five window registers
    task automatic apply_setting(input logic [31:0] fb, input logic [31:0] fe,
                                 input logic [31:0] sbase, input logic [31:0] se,
                                 input logic [31:0] gb);
        cfg_index_t  order [5];
        logic [31:0] vals [5];
        order = '{CFG_FLASH_BASE, CFG_FLASH_END, CFG_SRAM_BASE, CFG_SRAM_END, CFG_GUARD_BASE};
        vals  = '{fb, fe, sbase, se, gb};
        req_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        // write requests in flight give no result; let them retire
        repeat (4) @(negedge clk);
        for (int k = 0; k < 5; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= order[k];
            cfg_data  <= vals[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.set_window(order[k], vals[k]);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic random_phase(input int n, input bit all_quiet, input bit press);
        bit st;
        logic [31:0] insn;
        if (press)
            hold_requests++;
        for (int i = 0; i < n; i++)
        begin
            quiet = all_quiet || ((i / 40) % 4 == 3);
            if ($urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 1) != 0)
                    send_write(($urandom_range(0, 3) == 0) ? SP_INDEX
                               : 5'(8 + $urandom_range(0, 7)), pick_value());
                else
                    send_write(5'($urandom), pick_value());
            end else begin
                insn = pick_instr(st);
                send_decode(insn, pick_cause(st), pick_pc());
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin : stimulus
        logic [31:0] fb, sbase, gb;
        int drain_cycles;
        sb = new();
        quiet = 1'b0;
        hold_requests = 0;
        settings_used = 0;
        req_valid = 1'b0;
        req_data  = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FLASH_BASE;
        cfg_data  = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty windows after reset: nothing decodes
        send_decode(enc_i(OPC_LOAD, 3'd2, 5'd0, 12'd0), LD_CAUSE, 32'h0);

        fb = 32'h0800_0000;
        sbase = 32'h2000_0000;
        gb = 32'h2003_f000;
        apply_setting(fb, fb + 32'h0010_0000, sbase, sbase + 32'h0004_0000, gb);
        send_write(5'd0, 32'h0000_1000);
        send_write(SP_INDEX, gb - 32'd8);
        send_write(5'd8, 32'hffff_fff0);
        send_write(5'd15, 32'h8000_0000);
        send_write(5'd31, 32'hffff_ffff);
        send_decode(enc_i(OPC_LOAD, 3'd2, 5'd0, 12'h000), LD_CAUSE, fb);
        send_decode(enc_i(OPC_LOAD, 3'd4, 5'd31, 12'hfff), LD_CAUSE, fb + 32'd4);
        // store offset wraps the address past the top
        send_decode(enc_s(3'd2, 5'd8, 12'h7ff), ST_CAUSE, sbase);
        send_decode(enc_s(3'd3, 5'd8, 12'h010), ST_CAUSE, sbase);
        send_decode(enc_i(OPC_AMO, F3_AMO_W, 5'd15, 12'hfff), ST_CAUSE, fb);
        send_decode(enc_i(OPC_AMO, 3'd3, 5'd15, 12'h000), ST_CAUSE, fb);
        send_decode(enc_i(OPC_LOAD, 3'd3, 5'd0, 12'h004), LD_CAUSE, fb);
        send_decode(enc_i(OPC_LOAD, 3'd0, 5'd0, 12'h004), ST_CAUSE, fb);
        send_decode(enc_i(OPC_LOAD, 3'd1, 5'd0, 12'h004), LD_CAUSE | 32'h8000_0000, fb);
        send_decode(enc_cl(C_F3_LW, 3'd0, 7'h7c), LD_CAUSE, fb + 32'd2);
        send_decode(enc_cl(C_F3_SW, 3'd7, 7'h44), ST_CAUSE, fb + 32'd6);
        send_decode(enc_lwsp(5'd1, 8'h08), LD_CAUSE, sbase + 32'd2);
        send_decode(enc_lwsp(5'd0, 8'h08), LD_CAUSE, sbase + 32'd2);
        send_decode(enc_swsp(8'hfc), ST_CAUSE, sbase + 32'd10);
        // full-width word straddling the flash end fails, a halfword fits
        send_decode(enc_i(OPC_LOAD, 3'd5, 5'd0, 12'h000), LD_CAUSE, fb + 32'h000f_fffe);
        send_decode(enc_cl(C_F3_LW, 3'd1, 7'h00), LD_CAUSE, fb + 32'h000f_fffe);
        send_decode(enc_i(OPC_LOAD, 3'd2, 5'd0, 12'h000), LD_CAUSE, sbase + 32'h0003_fffc);
        send_decode(enc_cl(C_F3_LW, 3'd0, 7'h00), LD_CAUSE, 32'hffff_ffff);
        send_decode(enc_i(7'h13, 3'd2, 5'd0, 12'h000), LD_CAUSE, fb);
        send_decode(enc_i(OPC_LOAD, 3'd2, 5'd0, 12'h000), LD_CAUSE, fb - 32'd2);

        random_phase(290, 1'b0, 1'b0);

        // widest windows; guard base where its end wraps to zero
        apply_setting(32'h0, 32'hffff_ffff, 32'hffff_0000, 32'hffff_ffff, 32'hffff_ffe0);
        random_phase(260, 1'b0, 1'b0);

        // empty windows
        apply_setting(32'h0000_4000, 32'h0000_4000, 32'h9000_0000, 32'h0000_0100, 32'h0);
        random_phase(120, 1'b0, 1'b0);

        fb = $urandom;
        sbase = $urandom;
        apply_setting(fb, fb + $urandom_range(64, 65536), sbase,
                      sbase + $urandom_range(64, 65536), $urandom);
        random_phase(300, 1'b1, 1'b1);

        fb = $urandom;
        sbase = $urandom;
        apply_setting(fb, fb + $urandom_range(64, 1048576), sbase,
                      sbase + $urandom_range(64, 1048576), sbase + $urandom_range(0, 4096));
        random_phase(300, 1'b0, 1'b1);

        apply_setting(32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff, 32'hffff_ffdf);
        random_phase(250, 1'b0, 1'b0);

        req_valid <= 1'b0;
        drain_cycles = 0;
        while (sb.pending_results.size() != 0 && drain_cycles < 5000)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        repeat (8) @(negedge clk);
        if (sb.pending_results.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));

        $display("ran %0d requests (%0d register writes, %0d decodes) over %0d window settings",
                 sb.writes + sb.decodes, sb.writes, sb.decodes, settings_used);
        $display("%0d decodes found an address, %0d of them inside the stack guard",
                 sb.found_cnt, sb.guard_hits);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== riscv_fault_address_decoder.f =====
design/fad_pkg.sv
design/fad_ram.sv
design/fad_cfg_regs.sv
design/fad_decode.sv
design/riscv_fault_address_decoder.sv
tb/sv/testbench.sv
